// File: hdl/ctd_pkg.sv
package ctd_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned HANDLE_W = 12;
  localparam int unsigned COUNT_W  = 8;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SIGNAL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PASS   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_ALWAYS  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TIMED   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AVERAGE = 3'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hff;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_SIGNAL   = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_DONE     = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_SIG_RD,
    ST_SIG_WR,
    ST_SIG_REJ,
    ST_PASS_RD,
    ST_PASS_DIFF,
    ST_PASS_CMP,
    ST_PASS_WR,
    ST_PASS_DONE
  } state_e;

endpackage

// File: hdl/cooperative_task_dispatcher_core.sv
// Task slot table with add, signal and dispatch-pass commands, one command in
// flight at a time (in_ready_o is high only while idle). An add scans the
// active flags one slot per cycle and replies at the first free slot, or with
// a failed add after the last slot; a signal reads the memory, then updates it,
// while a rejected handle replies without a table read; a pass reads each slot,
// takes the elapsed time, compares it with the period and updates a due slot,
// then gives the done result. All time arithmetic goes through one shared
// 32-bit adder, and any cycle with a result pending waits until the output register is free.
module cooperative_task_dispatcher_core #(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ctd_pkg::FUNC_W-1:0]    in_func_i,
  input  logic [ctd_pkg::MODE_W-1:0]    in_task_mode_i,
  input  logic [ctd_pkg::TIME_W-1:0]    in_period_i,
  input  logic [ctd_pkg::HANDLE_W-1:0]  in_task_number_i,
  input  logic                          in_increment_i,
  input  logic [ctd_pkg::TIME_W-1:0]    in_now_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    out_kind_o,
  output logic [ctd_pkg::HANDLE_W-1:0]  out_slot_handle_o,
  output logic                          out_ok_o,
  output logic                          out_last_o
);

  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(TASK_SLOTS - 1);
  localparam logic [ctd_pkg::HANDLE_W-1:0] MaxHandle = ctd_pkg::HANDLE_W'(TASK_SLOTS);

  ctd_pkg::state_e state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;

  logic [ctd_pkg::MODE_W-1:0] mode_q;
  logic [ctd_pkg::TIME_W-1:0] period_q;
  logic [ctd_pkg::TIME_W-1:0] now_q;
  logic                       incr_q;

  logic [TASK_SLOTS-1:0] active_q;

  logic [ctd_pkg::MODE_W-1:0]  mem_mode   [TASK_SLOTS];
  logic [ctd_pkg::COUNT_W-1:0] mem_sig    [TASK_SLOTS];
  logic [ctd_pkg::TIME_W-1:0]  mem_period [TASK_SLOTS];
  logic [ctd_pkg::TIME_W-1:0]  mem_last   [TASK_SLOTS];

  logic [ctd_pkg::MODE_W-1:0]  rd_mode_q;
  logic [ctd_pkg::COUNT_W-1:0] rd_sig_q;
  logic [ctd_pkg::TIME_W-1:0]  rd_period_q;
  logic [ctd_pkg::TIME_W-1:0]  rd_last_q;

  logic [ctd_pkg::TIME_W-1:0] diff_q;
  logic                       ready_q, ready_d;

  logic [ctd_pkg::TIME_W-1:0] add_a, add_b;
  logic                       add_cin;
  logic [ctd_pkg::TIME_W:0]   add_sum;

  logic                 out_valid_q;
  ctd_pkg::kind_e       out_kind_q, emit_kind;
  logic [ctd_pkg::HANDLE_W-1:0] out_handle_q, emit_handle;
  logic                 out_ok_q, emit_ok_bit;
  logic                 out_last_q, emit_last;
  logic                 emit, out_free;

  logic                        wr_add, wr_sig, wr_last;
  logic [ctd_pkg::COUNT_W-1:0] wd_sig;
  logic [ctd_pkg::TIME_W-1:0]  wd_last;

  logic [ctd_pkg::HANDLE_W-1:0] handle_m1;
  logic                         handle_ok;
  logic                         sig_ok;
  logic                         in_xfer;

  assign in_ready_o = (state_q == ctd_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign handle_m1  = in_task_number_i - ctd_pkg::HANDLE_W'(1);
  assign handle_ok  = (in_task_number_i != '0) && (in_task_number_i <= MaxHandle);
  assign sig_ok     = incr_q || (rd_sig_q == '0);

  // shared adder
  always_comb begin
    add_a   = rd_last_q;
    add_b   = rd_period_q;
    add_cin = 1'b0;
    unique case (state_q)
      ctd_pkg::ST_PASS_DIFF: begin
        add_a   = now_q;
        add_b   = ~rd_last_q;
        add_cin = 1'b1;
      end
      ctd_pkg::ST_PASS_CMP: begin
        add_a   = diff_q;
        add_b   = ~rd_period_q;
        add_cin = 1'b1;
      end
      default: ;
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + (ctd_pkg::TIME_W+1)'(add_cin);

  always_comb begin
    ready_d = active_q[idx_q] &&
              ((rd_sig_q != '0) || (rd_mode_q == ctd_pkg::MODE_ALWAYS) ||
               (((rd_mode_q == ctd_pkg::MODE_TIMED) ||
                 (rd_mode_q == ctd_pkg::MODE_AVERAGE)) && add_sum[ctd_pkg::TIME_W]));
  end

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ctd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_func_i)
            ctd_pkg::FUNC_ADD: begin
              state_d = ctd_pkg::ST_ADD_SCAN;
              idx_d   = '0;
            end
            ctd_pkg::FUNC_SIGNAL: begin
              state_d = handle_ok ? ctd_pkg::ST_SIG_RD : ctd_pkg::ST_SIG_REJ;
              idx_d   = handle_ok ? handle_m1[IW-1:0] : '0;
            end
            ctd_pkg::FUNC_PASS: begin
              state_d = ctd_pkg::ST_PASS_RD;
              idx_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ctd_pkg::ST_ADD_SCAN: begin
        if (!active_q[idx_q] || idx_q == LastIdx) begin
          if (out_free) state_d = ctd_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ctd_pkg::ST_SIG_RD:  state_d = ctd_pkg::ST_SIG_WR;
      ctd_pkg::ST_SIG_WR,
      ctd_pkg::ST_SIG_REJ,
      ctd_pkg::ST_PASS_DONE: begin
        if (out_free) state_d = ctd_pkg::ST_IDLE;
      end
      ctd_pkg::ST_PASS_RD:   state_d = ctd_pkg::ST_PASS_DIFF;
      ctd_pkg::ST_PASS_DIFF: state_d = ctd_pkg::ST_PASS_CMP;
      ctd_pkg::ST_PASS_CMP:  state_d = ctd_pkg::ST_PASS_WR;
      ctd_pkg::ST_PASS_WR: begin
        if (!ready_q || out_free) begin
          if (idx_q == LastIdx) begin
            state_d = ctd_pkg::ST_PASS_DONE;
          end else begin
            state_d = ctd_pkg::ST_PASS_RD;
            idx_d   = idx_q + IW'(1);
          end
        end
      end
      default: state_d = ctd_pkg::ST_IDLE;
    endcase
  end

  // outputs and table writes
  always_comb begin
    emit        = 1'b0;
    emit_kind   = ctd_pkg::KIND_DONE;
    emit_handle = '0;
    emit_ok_bit = 1'b0;
    emit_last   = 1'b1;
    wr_add      = 1'b0;
    wr_sig      = 1'b0;
    wr_last     = 1'b0;
    wd_sig      = '0;
    wd_last     = now_q;
    unique case (state_q)
      ctd_pkg::ST_ADD_SCAN: begin
        emit_kind = ctd_pkg::KIND_ADD;
        if (!active_q[idx_q]) begin
          emit        = out_free;
          wr_add      = out_free;
          emit_handle = ctd_pkg::HANDLE_W'(idx_q) + ctd_pkg::HANDLE_W'(1);
          emit_ok_bit = 1'b1;
        end else if (idx_q == LastIdx) begin
          emit = out_free;
        end
      end
      ctd_pkg::ST_SIG_WR: begin
        emit        = out_free;
        emit_kind   = ctd_pkg::KIND_SIGNAL;
        emit_ok_bit = sig_ok;
        wr_sig      = out_free && sig_ok;
        wd_sig      = (rd_sig_q == ctd_pkg::COUNT_MAX) ? rd_sig_q
                                                       : rd_sig_q + ctd_pkg::COUNT_W'(1);
      end
      ctd_pkg::ST_SIG_REJ: begin
        emit      = out_free;
        emit_kind = ctd_pkg::KIND_SIGNAL;
      end
      ctd_pkg::ST_PASS_WR: begin
        emit_kind   = ctd_pkg::KIND_DISPATCH;
        emit_handle = ctd_pkg::HANDLE_W'(idx_q) + ctd_pkg::HANDLE_W'(1);
        emit_last   = 1'b0;
        if (ready_q) begin
          emit    = out_free;
          wr_sig  = out_free;
          wr_last = out_free;
        end
        wd_sig  = (rd_sig_q != '0) ? rd_sig_q - ctd_pkg::COUNT_W'(1) : rd_sig_q;
        wd_last = (rd_mode_q == ctd_pkg::MODE_AVERAGE) ? add_sum[ctd_pkg::TIME_W-1:0]
                                                       : now_q;
      end
      ctd_pkg::ST_PASS_DONE: begin
        emit = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctd_pkg::ST_IDLE;
      idx_q       <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (wr_add) active_q[idx_q] <= 1'b1;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q   <= in_task_mode_i;
      period_q <= in_period_i;
      now_q    <= in_now_time_i;
      incr_q   <= in_increment_i;
    end
    if (state_q == ctd_pkg::ST_PASS_DIFF) diff_q <= add_sum[ctd_pkg::TIME_W-1:0];
    if (state_q == ctd_pkg::ST_PASS_CMP) ready_q <= ready_d;
    if (emit) begin
      out_kind_q   <= emit_kind;
      out_handle_q <= emit_handle;
      out_ok_q     <= emit_ok_bit;
      out_last_q   <= emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_add) begin
      mem_mode[idx_q]   <= mode_q;
      mem_period[idx_q] <= period_q;
    end
    if (wr_add) begin
      mem_sig[idx_q] <= ctd_pkg::COUNT_W'(1);
    end else if (wr_sig) begin
      mem_sig[idx_q] <= wd_sig;
    end
    if (wr_add || wr_last) mem_last[idx_q] <= wd_last;
    rd_mode_q   <= mem_mode[idx_q];
    rd_sig_q    <= mem_sig[idx_q];
    rd_period_q <= mem_period[idx_q];
    rd_last_q   <= mem_last[idx_q];
  end

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = out_kind_q;
  assign out_slot_handle_o = out_handle_q;
  assign out_ok_o          = out_ok_q;
  assign out_last_o        = out_last_q;

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_kind_o == ctd_pkg::KIND_DISPATCH) == !out_last_o))
    else $error("last flag does not match result kind");

  a_dispatch_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == ctd_pkg::KIND_DISPATCH) |->
      (out_slot_handle_o != '0 && out_slot_handle_o <= MaxHandle))
    else $error("dispatch handle out of range");

  a_ok_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ok_o) |->
      (out_kind_o == ctd_pkg::KIND_ADD || out_kind_o == ctd_pkg::KIND_SIGNAL))
    else $error("ok set on a pass result");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ctd_pkg::ST_IDLE) |-> (idx_q <= LastIdx))
    else $error("slot index beyond table");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result loaded over a pending one");

endmodule

// File: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS        = 8;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 4 * SLOTS + 16;
  localparam int unsigned MAX_PRINTS   = 100;
  localparam int unsigned RANDOM_ITEMS = 80;

  localparam logic [ctd_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // modes that only run when signalled
  localparam logic [ctd_pkg::MODE_W-1:0] MODE_EVENT1 = 3'd1;
  localparam logic [ctd_pkg::MODE_W-1:0] MODE_EVENT4 = 3'd4;
  localparam logic [ctd_pkg::MODE_W-1:0] MODE_EVENT5 = 3'd5;
  localparam logic [ctd_pkg::MODE_W-1:0] MODE_EVENT6 = 3'd6;
  localparam logic [ctd_pkg::MODE_W-1:0] MODE_EVENT7 = 3'd7;

  typedef struct packed {
    logic [ctd_pkg::FUNC_W-1:0]   func;
    logic [ctd_pkg::MODE_W-1:0]   mode;
    logic [ctd_pkg::TIME_W-1:0]   period;
    logic [ctd_pkg::HANDLE_W-1:0] number;
    logic                         incr;
    logic [ctd_pkg::TIME_W-1:0]   now;
  } cmd_t;

  typedef struct packed {
    ctd_pkg::kind_e               kind;
    logic [ctd_pkg::HANDLE_W-1:0] handle;
    logic                         ok;
    logic                         last;
  } reply_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [ctd_pkg::FUNC_W-1:0]   in_func = '0;
  logic [ctd_pkg::MODE_W-1:0]   in_task_mode = '0;
  logic [ctd_pkg::TIME_W-1:0]   in_period = '0;
  logic [ctd_pkg::HANDLE_W-1:0] in_task_number = '0;
  logic                         in_increment = 1'b0;
  logic [ctd_pkg::TIME_W-1:0]   in_now_time = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [1:0]                   out_kind;
  logic [ctd_pkg::HANDLE_W-1:0] out_slot_handle;
  logic                         out_ok;
  logic                         out_last;

  // predicted slot table
  logic                         tbl_active   [SLOTS];
  logic [ctd_pkg::MODE_W-1:0]   tbl_mode     [SLOTS];
  logic [ctd_pkg::COUNT_W-1:0]  tbl_count    [SLOTS];
  logic [ctd_pkg::TIME_W-1:0]   tbl_period   [SLOTS];
  logic [ctd_pkg::TIME_W-1:0]   tbl_last_run [SLOTS];

  reply_t                       pending_replies[$];
  int unsigned                  mismatch_count = 0;
  int unsigned                  cycle_count = 0;
  int unsigned                  burst_left = 0;
  logic [ctd_pkg::TIME_W-1:0]   clock_ms = '0;

  cooperative_task_dispatcher_core #(
    .TASK_SLOTS(SLOTS)
  ) u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .in_func_i         (in_func),
    .in_task_mode_i    (in_task_mode),
    .in_period_i       (in_period),
    .in_task_number_i  (in_task_number),
    .in_increment_i    (in_increment),
    .in_now_time_i     (in_now_time),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .out_kind_o        (out_kind),
    .out_slot_handle_o (out_slot_handle),
    .out_ok_o          (out_ok),
    .out_last_o        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(input logic [ctd_pkg::FUNC_W-1:0] func,
                                    input logic [ctd_pkg::MODE_W-1:0] mode,
                                    input logic [ctd_pkg::TIME_W-1:0] period,
                                    input logic [ctd_pkg::HANDLE_W-1:0] number,
                                    input logic incr,
                                    input logic [ctd_pkg::TIME_W-1:0] now);
    cmd_t c;
    c.func   = func;
    c.mode   = mode;
    c.period = period;
    c.number = number;
    c.incr   = incr;
    c.now    = now;
    return c;
  endfunction

  function automatic reply_t make_reply(input ctd_pkg::kind_e kind,
                                        input int unsigned handle,
                                        input logic ok, input logic last);
    reply_t r;
    r.kind   = kind;
    r.handle = ctd_pkg::HANDLE_W'(handle);
    r.ok     = ok;
    r.last   = last;
    return r;
  endfunction

  function automatic bit slot_is_due(input int s, input logic [ctd_pkg::TIME_W-1:0] now);
    logic [ctd_pkg::TIME_W-1:0] elapsed;
    elapsed = now - tbl_last_run[s];
    if (!tbl_active[s]) return 1'b0;
    if (tbl_count[s] != '0) return 1'b1;
    if (tbl_mode[s] == ctd_pkg::MODE_ALWAYS) return 1'b1;
    if (tbl_mode[s] == ctd_pkg::MODE_TIMED || tbl_mode[s] == ctd_pkg::MODE_AVERAGE) begin
      return elapsed >= tbl_period[s];
    end
    return 1'b0;
  endfunction

  task automatic predict_cmd(input cmd_t c);
    bit placed;
    int s;
    logic ok;
    placed = 1'b0;
    ok = 1'b0;
    case (c.func)
      ctd_pkg::FUNC_ADD: begin
        for (s = 0; s < SLOTS && !placed; s++) begin
          if (!tbl_active[s]) begin
            tbl_active[s]   = 1'b1;
            tbl_mode[s]     = c.mode;
            tbl_count[s]    = ctd_pkg::COUNT_W'(1);
            tbl_period[s]   = c.period;
            tbl_last_run[s] = c.now;
            pending_replies.push_back(make_reply(ctd_pkg::KIND_ADD, s + 1, 1'b1, 1'b1));
            placed = 1'b1;
          end
        end
        if (!placed) begin
          pending_replies.push_back(make_reply(ctd_pkg::KIND_ADD, 0, 1'b0, 1'b1));
        end
      end
      ctd_pkg::FUNC_SIGNAL: begin
        if (c.number >= 1 && c.number <= SLOTS) begin
          s = int'(c.number) - 1;
          if (c.incr || tbl_count[s] == '0) begin
            if (tbl_count[s] != ctd_pkg::COUNT_MAX) tbl_count[s]++;
            ok = 1'b1;
          end
        end
        pending_replies.push_back(make_reply(ctd_pkg::KIND_SIGNAL, 0, ok, 1'b1));
      end
      ctd_pkg::FUNC_PASS: begin
        for (s = 0; s < SLOTS; s++) begin
          if (slot_is_due(s, c.now)) begin
            if (tbl_count[s] != '0) tbl_count[s]--;
            if (tbl_mode[s] == ctd_pkg::MODE_AVERAGE) begin
              tbl_last_run[s] = tbl_last_run[s] + tbl_period[s];
            end else begin
              tbl_last_run[s] = c.now;
            end
            pending_replies.push_back(make_reply(ctd_pkg::KIND_DISPATCH, s + 1, 1'b0, 1'b0));
          end
        end
        pending_replies.push_back(make_reply(ctd_pkg::KIND_DONE, 0, 1'b0, 1'b1));
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_cmd(input cmd_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_func        <= c.func;
    in_task_mode   <= c.mode;
    in_period      <= c.period;
    in_task_number <= c.number;
    in_increment   <= c.incr;
    in_now_time    <= c.now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_cmd(c);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // receiver stall pattern, re-chosen whenever stall_left runs out
  int unsigned      stall_style = 0;
  int unsigned      stall_left = 0;
  logic [7:0]       stall_mask = 8'hff;
  logic [2:0]       stall_phase = '0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_mask  = 8'($urandom) | 8'h01;
      stall_left  = $urandom_range(20, 120);
    end else begin
      stall_left--;
    end
    stall_phase = stall_phase + 3'd1;
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= stall_mask[stall_phase];
      default: out_ready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected result kind", 32'(out_kind), 32'hffff_ffff);
      end else begin
        want = pending_replies.pop_front();
        if (out_kind !== want.kind) report_mismatch("kind", 32'(out_kind), 32'(want.kind));
        if (out_slot_handle !== want.handle) begin
          report_mismatch("slot_handle", 32'(out_slot_handle), 32'(want.handle));
        end
        if (out_ok !== want.ok) report_mismatch("ok", 32'(out_ok), 32'(want.ok));
        if (out_last !== want.last) report_mismatch("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  task automatic test_empty_table();
    send_cmd(make_cmd(ctd_pkg::FUNC_PASS, ctd_pkg::MODE_ALWAYS, '0, '0, 1'b0, '0));
    send_cmd(make_cmd(ctd_pkg::FUNC_SIGNAL, ctd_pkg::MODE_ALWAYS, '0, '0, 1'b1, '0));
    send_cmd(make_cmd(ctd_pkg::FUNC_SIGNAL, ctd_pkg::MODE_ALWAYS, '0,
                      ctd_pkg::HANDLE_W'(SLOTS + 1), 1'b0, '0));
    send_cmd(make_cmd(ctd_pkg::FUNC_SIGNAL, MODE_EVENT7, '1, '1, 1'b1, '1));
    send_cmd(make_cmd(FUNC_UNUSED, MODE_EVENT7, '1, '1, 1'b1, '1));
  endtask

  task automatic test_fill_table();
    send_cmd(make_cmd(ctd_pkg::FUNC_ADD, ctd_pkg::MODE_ALWAYS, 32'h0, '0, 1'b0, 32'h0));
    send_cmd(make_cmd(ctd_pkg::FUNC_ADD, ctd_pkg::MODE_TIMED, 32'hffff_ffff, '0, 1'b0,
                      32'hffff_ffff));
    send_cmd(make_cmd(ctd_pkg::FUNC_ADD, ctd_pkg::MODE_AVERAGE, 32'd100, '0, 1'b0,
                      32'hffff_fff0));
    send_cmd(make_cmd(ctd_pkg::FUNC_ADD, MODE_EVENT1, 32'h5555_5555, '0, 1'b0,
                      32'haaaa_aaaa));
    send_cmd(make_cmd(ctd_pkg::FUNC_ADD, MODE_EVENT7, 32'haaaa_aaaa, '0, 1'b0,
                      32'h5555_5555));
    send_cmd(make_cmd(ctd_pkg::FUNC_ADD, ctd_pkg::MODE_TIMED, 32'd10, '0, 1'b0, 32'd1000));
    send_cmd(make_cmd(ctd_pkg::FUNC_ADD, ctd_pkg::MODE_AVERAGE, 32'd0, '0, 1'b0, 32'd5));
    send_cmd(make_cmd(ctd_pkg::FUNC_ADD, MODE_EVENT5, 32'd20, '0, 1'b0, 32'd0));
    // table is full from here on
    send_cmd(make_cmd(ctd_pkg::FUNC_ADD, MODE_EVENT4, 32'hffff_ffff, '1, 1'b1,
                      32'hffff_ffff));
    send_cmd(make_cmd(ctd_pkg::FUNC_ADD, MODE_EVENT6, 32'h0, '0, 1'b0, 32'h0));
    wait_for_results();
  endtask

  task automatic test_timed_dispatch();
    send_cmd(make_cmd(ctd_pkg::FUNC_PASS, ctd_pkg::MODE_ALWAYS, '0, '0, 1'b0, 32'd1000));
    send_cmd(make_cmd(ctd_pkg::FUNC_PASS, ctd_pkg::MODE_ALWAYS, '0, '0, 1'b0, 32'd1005));
    // elapsed wraps to all ones
    send_cmd(make_cmd(ctd_pkg::FUNC_PASS, ctd_pkg::MODE_ALWAYS, '0, '0, 1'b0, 32'd999));
    send_cmd(make_cmd(ctd_pkg::FUNC_PASS, ctd_pkg::MODE_ALWAYS, '0, '0, 1'b0, 32'd0));
  endtask

  task automatic test_signal_rules();
    send_cmd(make_cmd(ctd_pkg::FUNC_SIGNAL, ctd_pkg::MODE_ALWAYS, '0, 12'd4, 1'b0, '0));
    send_cmd(make_cmd(ctd_pkg::FUNC_SIGNAL, ctd_pkg::MODE_ALWAYS, '0, 12'd4, 1'b0, '0));
    send_cmd(make_cmd(ctd_pkg::FUNC_SIGNAL, ctd_pkg::MODE_ALWAYS, '0, 12'd4, 1'b1, '0));
    send_cmd(make_cmd(ctd_pkg::FUNC_PASS, ctd_pkg::MODE_ALWAYS, '0, '0, 1'b0, 32'd1010));
    send_cmd(make_cmd(ctd_pkg::FUNC_SIGNAL, ctd_pkg::MODE_ALWAYS, '0,
                      ctd_pkg::HANDLE_W'(SLOTS), 1'b1, '0));
    send_cmd(make_cmd(ctd_pkg::FUNC_PASS, ctd_pkg::MODE_ALWAYS, '0, '0, 1'b0, 32'd1020));
    wait_for_results();
  endtask

  task automatic test_count_saturation();
    repeat (ctd_pkg::COUNT_MAX + 2) begin
      send_cmd(make_cmd(ctd_pkg::FUNC_SIGNAL, ctd_pkg::MODE_ALWAYS, '0, 12'd5, 1'b1, '0));
    end
    send_cmd(make_cmd(ctd_pkg::FUNC_PASS, ctd_pkg::MODE_ALWAYS, '0, '0, 1'b0, 32'd1030));
    send_cmd(make_cmd(ctd_pkg::FUNC_SIGNAL, ctd_pkg::MODE_ALWAYS, '0, 12'd5, 1'b1, '0));
    clock_ms = 32'd1030;
  endtask

  task automatic test_random_traffic();
    cmd_t c;
    int unsigned pick;
    int unsigned step;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      c.func   = ctd_pkg::FUNC_W'($urandom);
      c.mode   = ctd_pkg::MODE_W'($urandom);
      c.period = $urandom;
      c.number = ctd_pkg::HANDLE_W'($urandom);
      c.incr   = 1'($urandom);
      c.now    = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        c.func = ctd_pkg::FUNC_PASS;
        step = $urandom_range(0, 19);
        if (step == 0) clock_ms = $urandom;
        else if (step == 1) clock_ms = clock_ms - $urandom_range(1, 50);
        else clock_ms = clock_ms + $urandom_range(0, 40);
        c.now = clock_ms;
      end else if (pick < 80) begin
        c.func   = ctd_pkg::FUNC_SIGNAL;
        c.number = ctd_pkg::HANDLE_W'($urandom_range(1, SLOTS));
      end else if (pick < 88) begin
        c.func = ctd_pkg::FUNC_SIGNAL;
      end else if (pick < 95) begin
        c.func = ctd_pkg::FUNC_ADD;
      end else begin
        c.func = FUNC_UNUSED;
      end
      // keep signals off slots that were never added
      if (c.func == ctd_pkg::FUNC_SIGNAL && c.number >= 1 && c.number <= SLOTS) begin
        if (!tbl_active[c.number - 1]) c.number = '0;
      end
      send_cmd(c);
      if (i == RANDOM_ITEMS / 2) wait_for_results();
    end
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      tbl_active[s]   = 1'b0;
      tbl_mode[s]     = '0;
      tbl_count[s]    = '0;
      tbl_period[s]   = '0;
      tbl_last_run[s] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_fill_table();
    test_timed_dispatch();
    test_signal_rules();
    test_count_saturation();
    test_random_traffic();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
